/* design/alins_pkg.sv */
// Shared types and constants for the array list insert unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package alins_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int ELEM_W   = 32;
   localparam int SLOT_W   = 6;
   localparam int STAT_W   = 2;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SHIFT = 5'b00010,
      S_PLACE = 5'b00100,
      S_EMIT  = 5'b01000,
      S_ERR   = 5'b10000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       shift;
      logic       place;
      logic       emit;
      logic       err_load;
      status_type err_code;
   } ctl_cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             shift_done;
      logic             emit_final;
      logic             err_ok;
   } dp_status_type;

endpackage

/* design/alins_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// Stands alone; holds the list elements of the insert unit.
module alins_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/alins_ctrl.sv */
// Controller state machine of the array list insert unit.
// Depends on alins_pkg; drives the datapath by command and reads its status.
module alins_ctrl
   import alins_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [POS_W-1:0]    req_position,
   input  dp_status_type       status,
   output ctl_cmd_type         cmd
);

   state_type        state_ff, state_in;
   status_type       err_ff, err_in;
   logic             accept;
   logic             is_full;
   logic             is_bad;
   logic [POS_W:0]   pos_ext;
   logic [POS_W:0]   limit;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign pos_ext   = {1'b0, req_position};
   assign limit     = (POS_W + 1)'(status.len) + (POS_W + 1)'(1);
   assign is_full   = (status.len == LEN_W'(CAPACITY));
   assign is_bad    = (req_position == '0) || (pos_ext > limit);

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      cmd          = '0;
      cmd.err_code = err_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (is_full) begin
                  err_in   = ST_FULL;
                  state_in = S_ERR;
               end else if (is_bad) begin
                  err_in   = ST_BAD_POS;
                  state_in = S_ERR;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_final) begin
               state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (status.err_ok) begin
               cmd.err_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

endmodule

/* design/alins_dp.sv */
// Datapath of the array list insert unit: length, pointers, element RAM,
// result register and skid stage. Depends on alins_pkg and alins_ram.
module alins_dp
   import alins_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [ELEM_W-1:0] req_value,
   input  ctl_cmd_type              cmd,
   output dp_status_type            status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic signed [ELEM_W-1:0] rsp_element,
   output logic                     rsp_last,
   output logic [STAT_W-1:0]        rsp_status
);

   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         ptr_ff, ptr_in;
   logic [LEN_W-1:0]         idx_ff, idx_in;
   logic [ELEM_W-1:0]        val_ff, val_in;
   logic                     wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]        wr_addr_ff, wr_addr_in;
   logic                     inflight_ff, inflight_in;
   logic [ADDR_W-1:0]        fl_slot_ff, fl_slot_in;
   logic                     fl_last_ff, fl_last_in;
   logic                     out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]        out_slot_ff, out_slot_in;
   logic [ELEM_W-1:0]        out_elem_ff, out_elem_in;
   logic                     out_last_ff, out_last_in;
   status_type               out_stat_ff, out_stat_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic [ADDR_W-1:0]        skid_slot_ff, skid_slot_in;
   logic [ELEM_W-1:0]        skid_elem_ff, skid_elem_in;
   logic                     skid_last_ff, skid_last_in;

   logic [LEN_W-1:0]         ptr_dec;
   logic                     shift_rd;
   logic                     can_issue;
   logic                     em_issue;
   logic                     is_final;
   logic                     pop;
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [ELEM_W-1:0]        ram_wr_data;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [ELEM_W-1:0]        ram_rd_data;

   assign ptr_dec   = ptr_ff - LEN_W'(1);
   assign shift_rd  = cmd.shift && (ptr_ff > idx_ff);
   assign can_issue = !skid_valid_ff && !(inflight_ff && out_valid_ff && rsp_stall);
   assign em_issue  = cmd.emit && can_issue;
   assign is_final  = (ptr_ff == (len_ff - LEN_W'(1)));
   assign pop       = out_valid_ff && !rsp_stall;

   assign status.len        = len_ff;
   assign status.shift_done = (ptr_ff == idx_ff) && !wr_pend_ff;
   assign status.emit_final = can_issue && is_final;
   assign status.err_ok     = !skid_valid_ff && !inflight_ff && (!out_valid_ff || !rsp_stall);

   assign ram_wr_en   = wr_pend_ff || cmd.place;
   assign ram_wr_addr = cmd.place ? idx_ff[ADDR_W-1:0] : wr_addr_ff;
   assign ram_wr_data = cmd.place ? val_ff : ram_rd_data;
   assign ram_rd_en   = shift_rd || em_issue;
   assign ram_rd_addr = cmd.shift ? ptr_dec[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];

   alins_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      len_in      = len_ff;
      ptr_in      = ptr_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      wr_pend_in  = shift_rd;
      wr_addr_in  = wr_addr_ff;
      inflight_in = em_issue;
      fl_slot_in  = fl_slot_ff;
      fl_last_in  = fl_last_ff;
      if (cmd.load) begin
         ptr_in = len_ff;
         idx_in = LEN_W'(req_position - POS_W'(1));
         val_in = req_value;
      end
      if (shift_rd) begin
         ptr_in     = ptr_dec;
         wr_addr_in = ptr_ff[ADDR_W-1:0];
      end
      if (cmd.place) begin
         len_in = len_ff + LEN_W'(1);
         ptr_in = '0;
      end
      if (em_issue) begin
         ptr_in     = ptr_ff + LEN_W'(1);
         fl_slot_in = ptr_ff[ADDR_W-1:0];
         fl_last_in = is_final;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_slot_in   = out_slot_ff;
      out_elem_in   = out_elem_ff;
      out_last_in   = out_last_ff;
      out_stat_in   = out_stat_ff;
      skid_valid_in = skid_valid_ff;
      skid_slot_in  = skid_slot_ff;
      skid_elem_in  = skid_elem_ff;
      skid_last_in  = skid_last_ff;
      if (cmd.err_load) begin
         out_valid_in = 1'b1;
         out_slot_in  = '0;
         out_elem_in  = '0;
         out_last_in  = 1'b1;
         out_stat_in  = cmd.err_code;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_slot_in   = skid_slot_ff;
            out_elem_in   = skid_elem_ff;
            out_last_in   = skid_last_ff;
            out_stat_in   = ST_OK;
            skid_valid_in = 1'b0;
         end
      end else if (inflight_ff) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_slot_in  = fl_slot_ff;
            out_elem_in  = ram_rd_data;
            out_last_in  = fl_last_ff;
            out_stat_in  = ST_OK;
         end else begin
            skid_valid_in = 1'b1;
            skid_slot_in  = fl_slot_ff;
            skid_elem_in  = ram_rd_data;
            skid_last_in  = fl_last_ff;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         ptr_ff        <= '0;
         wr_pend_ff    <= 1'b0;
         inflight_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         ptr_ff        <= ptr_in;
         wr_pend_ff    <= wr_pend_in;
         inflight_ff   <= inflight_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      wr_addr_ff   <= wr_addr_in;
      fl_slot_ff   <= fl_slot_in;
      fl_last_ff   <= fl_last_in;
      out_slot_ff  <= out_slot_in;
      out_elem_ff  <= out_elem_in;
      out_last_ff  <= out_last_in;
      out_stat_ff  <= out_stat_in;
      skid_slot_ff <= skid_slot_in;
      skid_elem_ff <= skid_elem_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_slot    = SLOT_W'(out_slot_ff);
   assign rsp_element = out_elem_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_status  = out_stat_ff;

endmodule

/* design/array_list_insert_at_position_unit.sv */
// Array list insert unit: inserts a value at a one-based position of a stored list
// and then streams the whole list out. Depends on alins_pkg, alins_ctrl and alins_dp.
//
// The req_ channel carries one insert per beat (position, value); a beat is taken
// when req_valid is high and req_stall is low. The rsp_ channel returns results,
// one per beat, under the same valid and stall rules.
// An accepted insert into a list of n elements at position p yields n+1 beats,
// slots 0 to n in order, status ok and last set on the final beat. An insert into
// a full store, or at a position of zero or beyond n+1, yields a single beat with
// slot 0, element 0, last set and the error status; the list is unchanged.
// The elements live in a single-port-write RAM, so the tail is moved one element
// at a time, from the end of the list down to the insert position, before the
// value is placed; the result reads then start at slot 0, and beats follow at one
// per cycle while the receiver does not stall. An error beat is loaded once the
// output and skid registers are free. req_stall stays high until every result
// read of the current insert has been issued; a new insert is taken while the
// last beats still wait at the output.
// A stalled result is held in the output register, with one skid stage behind it,
// and no beat is lost. Reset empties the list and drops any pending results.
module array_list_insert_at_position_unit
   import alins_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [ELEM_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic signed [ELEM_W-1:0] rsp_element,
   output logic                     rsp_last,
   output logic [STAT_W-1:0]        rsp_status
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   alins_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_position (req_position),
      .status       (status),
      .cmd          (cmd)
   );

   alins_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_position (req_position),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_slot     (rsp_slot),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status)
   );

endmodule
